>>> sv/tcce_pkg.sv
package tcce_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam int         TAB_STOP     = 8;
    localparam logic [7:0] ATTR_RESET   = 8'h02;
    localparam int         QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic [15:0] read_data;
    } out_item_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_BS,
        K_TAB,
        K_CR,
        K_LF,
        K_CHAR,
        K_CLEAR,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
        logic        in_range;
    } cmd_t;

endpackage

>>> sv/tcce_fifo.sv
module tcce_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    T              entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push_ok;
    logic          pop_ok;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> sv/tcce_front.sv
module tcce_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  tcce_pkg::in_item_t item,
    output tcce_pkg::cmd_t     cmd
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    always_comb
    begin
        cmd.char_code  = item.char_code;
        cmd.cell_index = item.cell_index;
        cmd.in_range   = ({21'd0, item.cell_index} < 32'(CELLS));
        cmd.kind       = K_NOP;
        case (item.opcode)
            OP_PUT:
            begin
                if (item.char_code == CH_BACKSPACE)
                begin
                    cmd.kind = K_BS;
                end
                else if (item.char_code == CH_TAB)
                begin
                    cmd.kind = K_TAB;
                end
                else if (item.char_code == CH_CR)
                begin
                    cmd.kind = K_CR;
                end
                else if (item.char_code == CH_LF)
                begin
                    cmd.kind = K_LF;
                end
                else if (item.char_code >= CH_SPACE)
                begin
                    cmd.kind = K_CHAR;
                end
            end
            OP_CLEAR: cmd.kind = K_CLEAR;
            OP_READ:  cmd.kind = K_READ;
            default:  cmd.kind = K_NOP;
        endcase
    end

endmodule

>>> sv/tcce_back.sv
module tcce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_attribute_we,
    input  logic [7:0]          text_attribute,
    input  logic                cmd_valid,
    input  tcce_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output tcce_pkg::out_item_t res,
    output logic                init_busy
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + TAB_STOP);
    localparam int RW    = $clog2(ROWS + 1);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_FILL   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [7:0]    attr_reg;
    logic          rdsel_reg, rdsel_next;
    logic [15:0]   rd_data_reg;
    logic [15:0]   mem [CELLS];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] offset;
    logic [CW-1:0] col_t;
    logic [RW-1:0] row_t;
    logic [15:0]   blank;

    assign blank     = {attr_reg, CH_SPACE};
    assign offset    = AW'(AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg));
    assign init_busy = (state_reg == ST_INIT);

    assign res.cursor_col    = 7'(col_reg);
    assign res.cursor_row    = 5'(row_reg);
    assign res.cursor_offset = 11'(offset);
    assign res.read_data     = rdsel_reg ? rd_data_reg : 16'd0;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        scan_next  = scan_reg;
        rdsel_next = rdsel_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        col_t      = col_reg;
        row_t      = row_reg;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = 16'd0;
                if (scan_reg == AW'(CELLS - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    rdsel_next = 1'b0;
                    state_next = ST_RESULT;
                    case (cmd.kind)
                        K_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_t = col_reg - 1'b1;
                            end
                        end
                        K_TAB:
                        begin
                            col_t = (col_reg + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
                        end
                        K_CR:
                        begin
                            col_t = '0;
                        end
                        K_LF:
                        begin
                            col_t = '0;
                            row_t = row_reg + 1'b1;
                        end
                        K_CHAR:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = offset;
                            mem_wdata = {attr_reg, cmd.char_code};
                            col_t     = col_reg + 1'b1;
                        end
                        K_CLEAR:
                        begin
                            col_t      = '0;
                            row_t      = '0;
                            scan_next  = '0;
                            state_next = ST_FILL;
                        end
                        K_READ:
                        begin
                            mem_re     = cmd.in_range;
                            mem_raddr  = AW'(cmd.cell_index);
                            rdsel_next = cmd.in_range;
                        end
                        default:
                        begin
                            col_t = col_reg;
                        end
                    endcase
                    if (col_t >= CW'(COLUMNS))
                    begin
                        col_t = '0;
                        row_t = row_t + 1'b1;
                    end
                    if (row_t >= RW'(ROWS))
                    begin
                        row_t      = RW'(ROWS - 1);
                        scan_next  = '0;
                        state_next = ST_SCROLL;
                    end
                    col_next = col_t;
                    row_next = row_t;
                end
            end
            ST_SCROLL:
            begin
                if (scan_reg != AW'(CELLS - COLUMNS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(scan_reg + AW'(COLUMNS));
                end
                if (scan_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = scan_reg - 1'b1;
                    mem_wdata = rd_data_reg;
                end
                if (scan_reg == AW'(CELLS - COLUMNS))
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = blank;
                if (scan_reg == AW'(CELLS - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            col_reg   <= '0;
            row_reg   <= '0;
            scan_reg  <= '0;
            rdsel_reg <= 1'b0;
            attr_reg  <= ATTR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            scan_reg  <= scan_next;
            rdsel_reg <= rdsel_next;
            if (text_attribute_we)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

>>> sv/text_console_char_engine.sv
// Channel     Direction  Handshake           Payload
// request     in         push / full         opcode, char_code, cell_index
// result      out        pop / empty         cursor_col, cursor_row, cursor_offset, read_data
// attribute   in         text_attribute_we   text_attribute
//
// A put, read or ignored byte passes through the executor's ST_IDLE and ST_RESULT states;
// ST_RESULT waits while the result queue is full.
// A scroll moves each row up in ST_SCROLL and blanks the last row in ST_FILL; a clear blanks all cells.
// After reset the store is cleared one cell a cycle with full held high.
// Two-entry queues sit on either side of the executor, so requests queue up while it is busy.
module text_console_char_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcce_pkg::in_item_t  request,
    output logic                full,
    input  logic                pop,
    output tcce_pkg::out_item_t result,
    output logic                empty,
    input  logic                text_attribute_we,
    input  logic [7:0]          text_attribute
);
    import tcce_pkg::*;

    cmd_t      front_cmd;
    cmd_t      queued_cmd;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      init_busy;
    logic      res_push;
    logic      res_full;
    out_item_t back_res;

    assign full = cmd_full || init_busy;

    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .item (request),
        .cmd  (front_cmd)
    );

    tcce_fifo #(
        .T     (cmd_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (queued_cmd),
        .empty (cmd_empty)
    );

    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .text_attribute_we (text_attribute_we),
        .text_attribute    (text_attribute),
        .cmd_valid         (!cmd_empty),
        .cmd               (queued_cmd),
        .cmd_pop           (cmd_pop),
        .res_full          (res_full),
        .res_push          (res_push),
        .res               (back_res),
        .init_busy         (init_busy)
    );

    tcce_fifo #(
        .T     (out_item_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
